>>> rtl/core/iaq_pkg.sv
package iaq_pkg;

    localparam int IAQ_QUEUE_DEPTH = 16;
    localparam int IAQ_CODE_W      = 16;
    localparam int IAQ_PAYLOAD_W   = 48;
    localparam int IAQ_WORD_W      = IAQ_CODE_W + IAQ_PAYLOAD_W;
    localparam int IAQ_STATE_W     = 32;
    localparam int IAQ_POS_W       = 32;

    typedef enum logic [2:0] {
        OP_APPEND       = 3'd0,
        OP_OVERWRITE    = 3'd1,
        OP_INSERT       = 3'd2,
        OP_CLEAR_ACTIVE = 3'd3,
        OP_CLEAR_QUEUE  = 3'd4,
        OP_CLEAR_ALL    = 3'd5,
        OP_MARK_ACTIVE  = 3'd6,
        OP_NONE         = 3'd7
    } iaq_opcode_t;

    typedef struct packed {
        logic append;
        logic overwrite;
        logic insert;
    } iaq_cmd_t;

endpackage

>>> rtl/core/iaq_cell.sv
module iaq_cell #(
    parameter int QUEUE_DEPTH = iaq_pkg::IAQ_QUEUE_DEPTH,
    parameter int IDX         = 0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  iaq_pkg::iaq_cmd_t                    cmd,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     pos,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     tail,
    input  logic [iaq_pkg::IAQ_WORD_W-1:0]       word,
    input  logic [iaq_pkg::IAQ_WORD_W-1:0]       prev,
    output logic [iaq_pkg::IAQ_WORD_W-1:0]       slot
);
    import iaq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [IAQ_WORD_W-1:0] slot_reg;
    logic [IAQ_WORD_W-1:0] slot_next;
    logic                  load;
    logic                  shift;

    assign load  = (cmd.overwrite && (IDX_C == '0))
                || (cmd.append && (IDX_C == tail))
                || (cmd.insert && (IDX_C == pos));
    assign shift = cmd.insert && (IDX_C > pos) && (IDX_C <= tail);

    always_comb
    begin
        slot_next = slot_reg;
        if (load)
        begin
            slot_next = word;
        end
        else if (shift)
        begin
            slot_next = prev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot = slot_reg;

endmodule

>>> rtl/core/iaq_ctrl.sv
module iaq_ctrl #(
    parameter int QUEUE_DEPTH = iaq_pkg::IAQ_QUEUE_DEPTH
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     accept,
    input  logic [2:0]                               operation,
    input  logic                                     load_states,
    input  logic signed [iaq_pkg::IAQ_STATE_W-1:0]   state_one_in,
    input  logic signed [iaq_pkg::IAQ_STATE_W-1:0]   state_two_in,
    input  logic signed [iaq_pkg::IAQ_POS_W-1:0]     insert_position,
    output iaq_pkg::iaq_cmd_t                        cmd,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]         pos,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]         tail,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]         count,
    output logic                                     active,
    output logic                                     overflow,
    output logic                                     done,
    output logic signed [iaq_pkg::IAQ_STATE_W-1:0]   state_one,
    output logic signed [iaq_pkg::IAQ_STATE_W-1:0]   state_two
);
    import iaq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    iaq_opcode_t             op;
    logic                    full;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic                    active_reg;
    logic                    active_next;
    logic                    overflow_reg;
    logic                    overflow_next;
    logic                    done_reg;
    logic [IAQ_STATE_W-1:0]  state_one_reg;
    logic [IAQ_STATE_W-1:0]  state_two_reg;

    assign op   = iaq_opcode_t'(operation);
    assign full = count_reg >= DEPTH_C;
    assign tail = count_reg + ONE_C;

    always_comb
    begin
        if ((count_reg == '0) && !active_reg)
        begin
            pos = ONE_C;
        end
        else if (insert_position[IAQ_POS_W-1])
        begin
            pos = '0;
        end
        else if (insert_position[IAQ_POS_W-2:0] > (IAQ_POS_W-1)'(count_reg))
        begin
            pos = tail;
        end
        else
        begin
            pos = insert_position[CW-1:0];
        end
    end

    always_comb
    begin
        cmd           = '0;
        count_next    = count_reg;
        active_next   = active_reg;
        overflow_next = 1'b0;
        if (accept)
        begin
            unique case (op)
                OP_APPEND, OP_INSERT:
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        cmd.append = (op == OP_APPEND);
                        cmd.insert = (op == OP_INSERT);
                        count_next = tail;
                    end
                end
                OP_OVERWRITE:    cmd.overwrite = 1'b1;
                OP_CLEAR_ACTIVE: active_next = 1'b0;
                OP_CLEAR_QUEUE:  count_next = '0;
                OP_CLEAR_ALL:
                begin
                    active_next = 1'b0;
                    count_next  = '0;
                end
                OP_MARK_ACTIVE:  active_next = 1'b1;
                OP_NONE:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            active_reg    <= 1'b0;
            overflow_reg  <= 1'b0;
            done_reg      <= 1'b0;
            state_one_reg <= '0;
            state_two_reg <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            active_reg   <= active_next;
            overflow_reg <= overflow_next;
            done_reg     <= accept;
            if (accept && load_states)
            begin
                state_one_reg <= state_one_in;
                state_two_reg <= state_two_in;
            end
        end
    end

    assign count     = count_reg;
    assign active    = active_reg;
    assign overflow  = overflow_reg;
    assign done      = done_reg;
    assign state_one = state_one_reg;
    assign state_two = state_two_reg;

`ifndef SYNTH
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("queued count above depth");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> (count_reg == DEPTH_C))
        else $error("overflow without full queue");

    a_transfer_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done_reg)
        else $error("transfer without result strobe");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg > $past(count_reg)) |-> (count_reg == $past(count_reg) + ONE_C))
        else $error("queued count grew by more than one");
`endif

endmodule

>>> rtl/core/insertable_action_queue.sv
// Insertable action queue: slot 0 holds the current action, slots 1..count
// hold queued actions, built as a chain of slot cells that shift in parallel.
// Input channel: start with operation, action_code, action_payload,
// load_states, state_one_in, state_two_in, insert_position; a transfer
// happens on a rising edge with start high and busy low. busy stays low, so
// a new command may be given on every cycle.
// Result channel: done is high for exactly one cycle, the cycle after the
// command transfer, with head_code, head_payload, queued_count, active_flag,
// overflow_flag, state_one_out and state_two_out showing the state after
// that command. Throughput is one command per cycle: every slot cell decides
// hold, load or shift from the broadcast command, and the position clamp is
// one compare against the count.
// The receiver cannot stall; each result is valid only while done is high.
// Reset clears all slots, the count, the active flag and the state words;
// no command is pending after reset.
module insertable_action_queue #(
    parameter int QUEUE_DEPTH = iaq_pkg::IAQ_QUEUE_DEPTH
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    output logic                                      busy,
    input  logic [2:0]                                operation,
    input  logic [iaq_pkg::IAQ_CODE_W-1:0]            action_code,
    input  logic [iaq_pkg::IAQ_PAYLOAD_W-1:0]         action_payload,
    input  logic                                      load_states,
    input  logic signed [iaq_pkg::IAQ_STATE_W-1:0]    state_one_in,
    input  logic signed [iaq_pkg::IAQ_STATE_W-1:0]    state_two_in,
    input  logic signed [iaq_pkg::IAQ_POS_W-1:0]      insert_position,
    output logic                                      done,
    output logic [iaq_pkg::IAQ_CODE_W-1:0]            head_code,
    output logic [iaq_pkg::IAQ_PAYLOAD_W-1:0]         head_payload,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]          queued_count,
    output logic                                      active_flag,
    output logic                                      overflow_flag,
    output logic signed [iaq_pkg::IAQ_STATE_W-1:0]    state_one_out,
    output logic signed [iaq_pkg::IAQ_STATE_W-1:0]    state_two_out
);
    import iaq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    iaq_cmd_t              cmd;
    logic [CW-1:0]         pos;
    logic [CW-1:0]         tail;
    logic                  accept;
    logic [IAQ_WORD_W-1:0] word;
    logic [IAQ_WORD_W-1:0] slot_q [QUEUE_DEPTH+1];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign word   = {action_payload, action_code};

    iaq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .operation       (operation),
        .load_states     (load_states),
        .state_one_in    (state_one_in),
        .state_two_in    (state_two_in),
        .insert_position (insert_position),
        .cmd             (cmd),
        .pos             (pos),
        .tail            (tail),
        .count           (queued_count),
        .active          (active_flag),
        .overflow        (overflow_flag),
        .done            (done),
        .state_one       (state_one_out),
        .state_two       (state_two_out)
    );

    for (genvar i = 0; i <= QUEUE_DEPTH; i++)
    begin : g_cell
        logic [IAQ_WORD_W-1:0] prev;
        if (i == 0)
        begin : g_head
            assign prev = '0;
        end
        else
        begin : g_body
            assign prev = slot_q[i-1];
        end

        iaq_cell #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .IDX         (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .pos   (pos),
            .tail  (tail),
            .word  (word),
            .prev  (prev),
            .slot  (slot_q[i])
        );
    end

    assign head_code    = slot_q[0][IAQ_CODE_W-1:0];
    assign head_payload = slot_q[0][IAQ_WORD_W-1:IAQ_CODE_W];

endmodule

>>> tb/sv/insertable_action_queue_tb.sv
`timescale 1ns / 1ps

module insertable_action_queue_tb;

    import iaq_pkg::*;

    localparam int DEPTH      = IAQ_QUEUE_DEPTH;
    localparam int ITEM_COUNT = 1100;
    localparam int CALM_TAIL  = 150;

    typedef struct {
        iaq_opcode_t        op;
        logic [15:0]        code;
        logic [47:0]        payload;
        logic               load;
        logic signed [31:0] state_one;
        logic signed [31:0] state_two;
        logic signed [31:0] pos;
    } action_cmd_t;

    typedef struct {
        logic [15:0]        code;
        logic [47:0]        payload;
        logic [4:0]         count;
        logic               active;
        logic               overflow;
        logic signed [31:0] state_one;
        logic signed [31:0] state_two;
    } queue_snap_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         operation = OP_NONE;
    logic [15:0]        action_code = '0;
    logic [47:0]        action_payload = '0;
    logic               load_states = 1'b0;
    logic signed [31:0] state_one_in = '0;
    logic signed [31:0] state_two_in = '0;
    logic signed [31:0] insert_position = '0;
    logic               done;
    logic [15:0]        head_code;
    logic [47:0]        head_payload;
    logic [4:0]         queued_count;
    logic               active_flag;
    logic               overflow_flag;
    logic signed [31:0] state_one_out;
    logic signed [31:0] state_two_out;

    action_cmd_t pending_cmds[$];
    queue_snap_t expected_snaps[$];
    action_cmd_t cur_cmd;
    int          total_cmds = ITEM_COUNT;
    int          sent_count = 0;
    int          gap_left = 0;
    int          idle_odds = 1;
    int          mismatch_count = 0;

    logic [63:0]        model_slots[0:DEPTH];
    int                 model_count = 0;
    logic               model_active = 1'b0;
    logic signed [31:0] model_state_one = '0;
    logic signed [31:0] model_state_two = '0;

    insertable_action_queue dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic queue_snap_t step_queue_model(action_cmd_t c);
        queue_snap_t s;
        logic [63:0] word;
        longint      p;
        int          i;
        word = {c.payload, c.code};
        s.overflow = 1'b0;
        if (c.load)
        begin
            model_state_one = c.state_one;
            model_state_two = c.state_two;
        end
        case (c.op)
            OP_APPEND, OP_INSERT:
            begin
                if (model_count >= DEPTH)
                    s.overflow = 1'b1;
                else if (c.op == OP_APPEND)
                begin
                    model_slots[model_count + 1] = word;
                    model_count++;
                end
                else
                begin
                    p = longint'(c.pos);
                    if (model_count == 0 && !model_active)
                        p = longint'(1);
                    if (p > longint'(model_count))
                        p = longint'(model_count + 1);
                    if (p < longint'(0))
                        p = longint'(0);
                    for (i = model_count + 1; longint'(i) > p; i--)
                        model_slots[i] = model_slots[i - 1];
                    model_slots[int'(p)] = word;
                    model_count++;
                end
            end
            OP_OVERWRITE:    model_slots[0] = word;
            OP_CLEAR_ACTIVE: model_active = 1'b0;
            OP_CLEAR_QUEUE:  model_count = 0;
            OP_CLEAR_ALL:
            begin
                model_active = 1'b0;
                model_count = 0;
            end
            OP_MARK_ACTIVE:  model_active = 1'b1;
            default:         ;
        endcase
        s.code      = model_slots[0][15:0];
        s.payload   = model_slots[0][63:16];
        s.count     = model_count[4:0];
        s.active    = model_active;
        s.state_one = model_state_one;
        s.state_two = model_state_two;
        return s;
    endfunction

    function automatic action_cmd_t random_cmd(iaq_opcode_t op);
        action_cmd_t c;
        c.op        = op;
        c.code      = 16'($urandom);
        c.payload   = {16'($urandom), 32'($urandom)};
        c.load      = ($urandom_range(0, 3) == 0);
        c.state_one = $urandom;
        c.state_two = $urandom;
        case ($urandom_range(0, 9))
            0:       c.pos = $urandom;
            1:       c.pos = -int'($urandom_range(1, 3));
            2:       c.pos = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: c.pos = $urandom_range(0, DEPTH + 2);
        endcase
        return c;
    endfunction

    task automatic push_cmd(iaq_opcode_t op, logic [15:0] code, logic [47:0] payload,
                            logic load, logic signed [31:0] s1, logic signed [31:0] s2,
                            logic signed [31:0] pos);
        action_cmd_t c;
        c.op        = op;
        c.code      = code;
        c.payload   = payload;
        c.load      = load;
        c.state_one = s1;
        c.state_two = s2;
        c.pos       = pos;
        pending_cmds.push_back(c);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatch_count < 100)
            $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic take_next;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            take_next = 1'b1;
            if (start && !busy)
            begin
                expected_snaps.push_back(step_queue_model(cur_cmd));
                sent_count++;
                if ($urandom_range(0, 49) == 0)
                    idle_odds = $urandom_range(0, 2);
            end
            else if (start)
                take_next = 1'b0;
            if (take_next)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() == 0)
                    start <= 1'b0;
                else if (sent_count < total_cmds - CALM_TAIL &&
                         ((idle_odds == 1 && $urandom_range(0, 7) == 0) ||
                          (idle_odds == 2 && $urandom_range(0, 2) == 0)))
                begin
                    gap_left = $urandom_range(0, 11);
                    start <= 1'b0;
                end
                else
                begin
                    cur_cmd = pending_cmds.pop_front();
                    start           <= 1'b1;
                    operation       <= cur_cmd.op;
                    action_code     <= cur_cmd.code;
                    action_payload  <= cur_cmd.payload;
                    load_states     <= cur_cmd.load;
                    state_one_in    <= cur_cmd.state_one;
                    state_two_in    <= cur_cmd.state_two;
                    insert_position <= cur_cmd.pos;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        queue_snap_t want;
        if (done)
        begin
            if (expected_snaps.size() == 0)
                report_mismatch("result with nothing outstanding", {16'h0, head_payload},
                                64'h0);
            else
            begin
                want = expected_snaps.pop_front();
                if (head_code !== want.code)
                    report_mismatch("head_code", {48'h0, head_code}, {48'h0, want.code});
                if (head_payload !== want.payload)
                    report_mismatch("head_payload", {16'h0, head_payload},
                                    {16'h0, want.payload});
                if (queued_count !== want.count)
                    report_mismatch("queued_count", {59'h0, queued_count},
                                    {59'h0, want.count});
                if (active_flag !== want.active)
                    report_mismatch("active_flag", {63'h0, active_flag},
                                    {63'h0, want.active});
                if (overflow_flag !== want.overflow)
                    report_mismatch("overflow_flag", {63'h0, overflow_flag},
                                    {63'h0, want.overflow});
                if (state_one_out !== want.state_one)
                    report_mismatch("state_one_out", {32'h0, state_one_out},
                                    {32'h0, want.state_one});
                if (state_two_out !== want.state_two)
                    report_mismatch("state_two_out", {32'h0, state_two_out},
                                    {32'h0, want.state_two});
            end
        end
    end

    initial
    begin
        int i;
        int n;
        int kind;
        bit first_episode;
        for (i = 0; i <= DEPTH; i++)
            model_slots[i] = '0;

        push_cmd(OP_NONE, '0, '0, 1'b0, '0, '0, '0);
        push_cmd(OP_INSERT, '1, '1, 1'b1, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd0);
        push_cmd(OP_MARK_ACTIVE, '0, '0, 1'b0, '1, '1, '0);
        push_cmd(OP_OVERWRITE, '1, '1, 1'b1, 32'sh8000_0000, 32'sh7fff_ffff, '0);
        push_cmd(OP_INSERT, 16'h1234, 48'h0123_4567_89ab, 1'b0, '0, '0, 32'sh8000_0000);
        push_cmd(OP_INSERT, 16'h0001, 48'h0000_0000_0001, 1'b0, '0, '0, 32'sh7fff_ffff);
        push_cmd(OP_APPEND, 16'h8000, 48'h8000_0000_0000, 1'b1, '1, '0, '0);
        push_cmd(OP_INSERT, 16'h5a5a, 48'ha5a5_a5a5_a5a5, 1'b0, '0, '0, 32'sd1);
        push_cmd(OP_CLEAR_ACTIVE, '0, '0, 1'b0, '0, '0, '0);
        push_cmd(OP_INSERT, 16'h00ff, 48'hff00_ff00_ff00, 1'b0, '0, '0, 32'sd0);
        push_cmd(OP_INSERT, 16'hbeef, 48'h0000_ffff_0000, 1'b0, '0, '0, -32'sd1);
        push_cmd(OP_CLEAR_QUEUE, '0, '0, 1'b0, '0, '0, '0);
        push_cmd(OP_INSERT, 16'h7777, 48'h7777_7777_7777, 1'b0, '0, '0, 32'sd5);
        push_cmd(OP_MARK_ACTIVE, '0, '0, 1'b0, '0, '0, '0);
        push_cmd(OP_CLEAR_QUEUE, '0, '0, 1'b0, '0, '0, '0);
        push_cmd(OP_INSERT, 16'h4242, 48'h4242_4242_4242, 1'b0, '0, '0, 32'sd0);
        push_cmd(OP_CLEAR_ALL, '0, '0, 1'b0, '0, '0, '0);
        push_cmd(OP_NONE, '1, '1, 1'b1, '0, '0, '1);

        first_episode = 1'b1;
        while (pending_cmds.size() < ITEM_COUNT)
        begin
            kind = first_episode ? 4 : $urandom_range(0, 9);
            first_episode = 1'b0;
            case (kind)
                0, 1, 2, 3:
                begin
                    n = $urandom_range(4, 20);
                    for (i = 0; i < n; i++)
                        pending_cmds.push_back(random_cmd(
                            $urandom_range(0, 1) ? OP_APPEND : OP_INSERT));
                end
                4:
                begin
                    for (i = 0; i < DEPTH + 3; i++)
                        pending_cmds.push_back(random_cmd(
                            $urandom_range(0, 1) ? OP_APPEND : OP_INSERT));
                end
                5:
                    pending_cmds.push_back(random_cmd(
                        iaq_opcode_t'($urandom_range(OP_CLEAR_ACTIVE, OP_CLEAR_ALL))));
                6:  pending_cmds.push_back(random_cmd(OP_MARK_ACTIVE));
                7:  pending_cmds.push_back(random_cmd(OP_OVERWRITE));
                default:
                begin
                    n = $urandom_range(3, 8);
                    for (i = 0; i < n; i++)
                        pending_cmds.push_back(random_cmd(
                            iaq_opcode_t'($urandom_range(0, 7))));
                end
            endcase
        end
        total_cmds = pending_cmds.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || start || expected_snaps.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout waiting for results");
        $display("DONE: errors detected");
        $finish;
    end

endmodule
